// ===== hdl/jsm_pkg.sv =====
// Shared types and constants for the joystick servo mapper.
package jsm_pkg;

    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_UNIT   = 2'd1,
        MODE_MUTE   = 2'd2,
        MODE_TICK   = 2'd3
    } t_mode;

    // configuration register indexes
    localparam logic [1:0] CFG_GAIN    = 2'd0;
    localparam logic [1:0] CFG_OFFSET  = 2'd1;
    localparam logic [1:0] CFG_LOCKOUT = 2'd2;

    localparam logic [17:0] GAIN_RESET    = 18'd104890;
    localparam logic [15:0] OFFSET_RESET  = 16'd1638;
    localparam logic [9:0]  LOCKOUT_RESET = 10'd100;

    // level thresholds in Q16, 33 bits to cover the full scaled range
    localparam logic [32:0] DEAD_LOW_Q  = 33'd4800 << 16;
    localparam logic [32:0] DEAD_HIGH_Q = 33'd5100 << 16;
    localparam logic [32:0] END_LOW_Q   = 33'd1700 << 16;
    localparam logic [32:0] END_HIGH_Q  = 33'd8100 << 16;

    localparam logic [15:0] LEVEL_LOW_CLAMP  = 16'd1638;
    localparam logic [15:0] LEVEL_HIGH_CLAMP = 16'd8192;
    localparam logic [15:0] LEVEL_CENTER     = 16'd4916;
    localparam logic [7:0]  BUZZ_ON          = 8'd127;
    localparam logic [10:0] AGE_MAX          = 11'd2047;

    // round(1800*s/4095) = floor((3600*s + 4095) * M / 2^37), M = ceil(2^37/8190)
    localparam int unsigned TENTHS_SHIFT = 37;
    localparam logic [48:0] TENTHS_RECIP = 49'd16781314;
    localparam logic [48:0] TENTHS_MUL   = TENTHS_RECIP * 49'd3600;
    localparam logic [48:0] TENTHS_ADD   = TENTHS_RECIP * 49'd4095;
    localparam logic [11:0] CENTER_TENTHS = 12'd900;

    typedef struct packed {
        logic [15:0]        servo_level;
        logic               buzz_a_on;
        logic               buzz_b_on;
        logic               buzz_clear;
        logic signed [11:0] position;
    } t_map_res;

    typedef struct packed {
        logic muted;
        logic unit;
    } t_flags;

endpackage

// ===== hdl/jsm_map.sv =====
// Sample to servo level, buzzer action and position, one combinational pass.
module jsm_map
    import jsm_pkg::*;
(
    input  logic [11:0] i_sample,
    input  logic [17:0] i_gain,
    input  logic [15:0] i_offset,
    input  t_flags      i_flags,
    output t_map_res    o_res
);

    logic [32:0] w_lvl;
    logic [48:0] w_tenths_prod;
    logic [10:0] w_tenths;

    assign w_lvl = 33'({i_sample} * {i_gain}) + {1'b0, i_offset, 16'd0};

    assign w_tenths_prod = 49'(49'(i_sample) * TENTHS_MUL) + TENTHS_ADD;
    assign w_tenths      = w_tenths_prod[TENTHS_SHIFT +: 11];

    always_comb begin
        o_res.buzz_a_on  = 1'b0;
        o_res.buzz_b_on  = 1'b0;
        o_res.buzz_clear = 1'b0;
        priority if (w_lvl > DEAD_LOW_Q && w_lvl < DEAD_HIGH_Q) begin
            o_res.servo_level = LEVEL_CENTER;
        end else if (w_lvl < END_LOW_Q) begin
            o_res.servo_level = LEVEL_LOW_CLAMP;
            o_res.buzz_a_on   = !i_flags.muted;
        end else if (w_lvl > END_HIGH_Q) begin
            o_res.servo_level = LEVEL_HIGH_CLAMP;
            o_res.buzz_b_on   = !i_flags.muted;
        end else begin
            // here the level is at most 8100, so the integer part fits
            o_res.servo_level = w_lvl[31:16];
            o_res.buzz_clear  = 1'b1;
        end
        if (i_flags.unit) begin
            o_res.position = $signed({1'b0, w_tenths} - CENTER_TENTHS);
        end else begin
            o_res.position = $signed({1'b0, w_tenths});
        end
    end

endmodule

// ===== hdl/jsm_ctrl.sv =====
// Button lockout counter and the mute and unit flags.
module jsm_ctrl
    import jsm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  t_mode      i_mode,
    input  logic [9:0] i_lockout,
    output t_flags     o_flags
);

    logic [10:0] r_press_age, n_press_age;
    t_flags      r_flags, n_flags;
    logic        w_press_ok;

    assign w_press_ok = r_press_age > {1'b0, i_lockout};

    always_comb begin
        n_press_age = r_press_age;
        n_flags     = r_flags;
        if (i_fire) begin
            unique case (i_mode)
                MODE_SAMPLE: begin
                end
                MODE_UNIT: begin
                    if (w_press_ok) begin
                        n_press_age  = '0;
                        n_flags.unit = !r_flags.unit;
                    end
                end
                MODE_MUTE: begin
                    if (w_press_ok) begin
                        n_press_age   = '0;
                        n_flags.muted = !r_flags.muted;
                    end
                end
                MODE_TICK: begin
                    if (r_press_age != AGE_MAX) begin
                        n_press_age = r_press_age + 11'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_age <= '0;
            r_flags     <= '0;
        end else begin
            r_press_age <= n_press_age;
            r_flags     <= n_flags;
        end
    end

    assign o_flags = r_flags;

endmodule

// ===== hdl/joystick_servo_mapper.sv =====
// Top level of the joystick servo mapper: input stage, state and result registers.
// Every item is a joystick sample, a unit or mute button press, or a 1 ms tick, and each
// gives one result: the servo level, both buzzer levels, the position in tenths of a
// degree and the two flags as they stand after that item. The block takes one item per
// clock while its results are taken; an accepted item waits in the input register, then
// passes once through the scaling multiply and compares into the result registers. A
// stalled result holds the next item in the input register, so at most two items are
// in flight. Configuration writes take effect at once and belong between items.
module joystick_servo_mapper
    import jsm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [17:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_mode,
    input  logic [11:0]        i_sample,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [15:0]        o_servo_level,
    output logic [7:0]         o_buzzer_a_level,
    output logic [7:0]         o_buzzer_b_level,
    output logic signed [11:0] o_position_tenths,
    output logic               o_muted,
    output logic               o_centered_units
);

    logic [17:0]        r_gain;
    logic [15:0]        r_offset;
    logic [9:0]         r_lockout;
    logic               r_in_valid;
    t_mode              r_mode;
    logic [11:0]        r_sample;
    logic               r_out_valid;
    logic [15:0]        r_servo;
    logic [7:0]         r_buzz_a;
    logic [7:0]         r_buzz_b;
    logic signed [11:0] r_position;
    logic               w_fire;
    logic               w_in_acc;
    t_flags             w_flags;
    t_map_res           w_map;

    assign w_fire     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_fire;
    assign w_in_acc   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain    <= GAIN_RESET;
            r_offset  <= OFFSET_RESET;
            r_lockout <= LOCKOUT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GAIN:    r_gain    <= i_cfg_data;
                CFG_OFFSET:  r_offset  <= i_cfg_data[15:0];
                CFG_LOCKOUT: r_lockout <= i_cfg_data[9:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mode   <= t_mode'(i_mode);
            r_sample <= i_sample;
        end
    end

    jsm_map u_map (
        .i_sample (r_sample),
        .i_gain   (r_gain),
        .i_offset (r_offset),
        .i_flags  (w_flags),
        .o_res    (w_map)
    );

    jsm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_fire),
        .i_mode    (r_mode),
        .i_lockout (r_lockout),
        .o_flags   (w_flags)
    );

    // the state registers are the result registers; they only move when a result is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_servo     <= '0;
            r_buzz_a    <= '0;
            r_buzz_b    <= '0;
            r_position  <= '0;
        end else begin
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_fire && r_mode == MODE_SAMPLE) begin
                r_servo    <= w_map.servo_level;
                r_position <= w_map.position;
                if (w_map.buzz_clear) begin
                    r_buzz_a <= '0;
                    r_buzz_b <= '0;
                end
                if (w_map.buzz_a_on) begin
                    r_buzz_a <= BUZZ_ON;
                end
                if (w_map.buzz_b_on) begin
                    r_buzz_b <= BUZZ_ON;
                end
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_servo_level     = r_servo;
    assign o_buzzer_a_level  = r_buzz_a;
    assign o_buzzer_b_level  = r_buzz_b;
    assign o_position_tenths = r_position;
    assign o_muted           = w_flags.muted;
    assign o_centered_units  = w_flags.unit;

    a_ready_low_holds_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_valid)
        else $error("input stage refuses an item while empty");

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("processed item produced no result");

    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> $stable(r_servo) && $stable(r_position)
            && $stable(w_flags) && $stable(r_buzz_a) && $stable(r_buzz_b))
        else $error("state moved under a stalled result");

    a_buzz_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_buzz_a == 8'd0 || r_buzz_a == BUZZ_ON) && (r_buzz_b == 8'd0 || r_buzz_b == BUZZ_ON))
        else $error("buzzer level outside its two values");

endmodule

// ===== test/joystick_servo_mapper_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for joystick_servo_mapper: predicts and checks every result item.
module joystick_servo_mapper_tb;
    import jsm_pkg::*;

    localparam int unsigned TENTHS_FULL = 1800;
    localparam int unsigned ADC_FULL    = 4095;

    typedef struct packed {
        logic [15:0] servo_level;
        logic [7:0]  buzzer_a;
        logic [7:0]  buzzer_b;
        logic [11:0] position;
        logic        muted;
        logic        units;
    } t_mapper_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [17:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  mode;
    logic [11:0] sample;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] servo_level;
    logic [7:0]  buzzer_a_level;
    logic [7:0]  buzzer_b_level;
    logic signed [11:0] position_tenths;
    logic        muted;
    logic        centered_units;

    // mirror of the block's configuration and state
    logic [17:0] gain_q16;
    logic [15:0] level_offset;
    logic [9:0]  lockout_ticks;
    t_mapper_out mapper_state;
    logic [10:0] press_age;

    t_mapper_out pending_results[$];
    bit failed       = 1'b0;
    bit gaps_on      = 1'b1;
    bit stalls_on    = 1'b1;
    int hold_request = 0;

    always #5 i_clk = ~i_clk;

    joystick_servo_mapper u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_mode            (mode),
        .i_sample          (sample),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_servo_level     (servo_level),
        .o_buzzer_a_level  (buzzer_a_level),
        .o_buzzer_b_level  (buzzer_b_level),
        .o_position_tenths (position_tenths),
        .o_muted           (muted),
        .o_centered_units  (centered_units)
    );

    function automatic bit take_press();
        if (press_age > lockout_ticks) begin
            press_age = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // update the mirrored state for one item and queue the result it causes
    function automatic void apply_event(t_mode m, logic [11:0] s);
        logic [63:0] lvl;
        logic [31:0] tenths;
        case (m)
            MODE_SAMPLE: begin
                lvl = 64'(s) * 64'(gain_q16) + (64'(level_offset) << 16);
                if (lvl > 64'(DEAD_LOW_Q) && lvl < 64'(DEAD_HIGH_Q)) begin
                    mapper_state.servo_level = LEVEL_CENTER;
                end else if (lvl < 64'(END_LOW_Q)) begin
                    mapper_state.servo_level = LEVEL_LOW_CLAMP;
                    if (!mapper_state.muted) mapper_state.buzzer_a = BUZZ_ON;
                end else if (lvl > 64'(END_HIGH_Q)) begin
                    mapper_state.servo_level = LEVEL_HIGH_CLAMP;
                    if (!mapper_state.muted) mapper_state.buzzer_b = BUZZ_ON;
                end else begin
                    mapper_state.servo_level = lvl[31:16];
                    mapper_state.buzzer_a = '0;
                    mapper_state.buzzer_b = '0;
                end
                // rounded to nearest tenth of a degree
                tenths = (2 * TENTHS_FULL * 32'(s) + ADC_FULL) / (2 * ADC_FULL);
                if (mapper_state.units) tenths = tenths - 32'(CENTER_TENTHS);
                mapper_state.position = tenths[11:0];
            end
            MODE_UNIT: if (take_press()) mapper_state.units = ~mapper_state.units;
            MODE_MUTE: if (take_press()) mapper_state.muted = ~mapper_state.muted;
            default:   if (press_age != AGE_MAX) press_age = press_age + 11'd1;
        endcase
        pending_results.push_back(mapper_state);
    endfunction

    always @(posedge i_clk) begin : check_results
        t_mapper_out want;
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result item: servo_level %0d", servo_level);
                failed = 1'b1;
            end else begin
                want = pending_results.pop_front();
                if (servo_level !== want.servo_level) begin
                    $error("servo_level: expected %0d, got %0d", want.servo_level, servo_level);
                    failed = 1'b1;
                end
                if (buzzer_a_level !== want.buzzer_a) begin
                    $error("buzzer_a_level: expected %0d, got %0d", want.buzzer_a,
                           buzzer_a_level);
                    failed = 1'b1;
                end
                if (buzzer_b_level !== want.buzzer_b) begin
                    $error("buzzer_b_level: expected %0d, got %0d", want.buzzer_b,
                           buzzer_b_level);
                    failed = 1'b1;
                end
                if (position_tenths !== want.position) begin
                    $error("position_tenths: expected %0d, got %0d", $signed(want.position),
                           position_tenths);
                    failed = 1'b1;
                end
                if (muted !== want.muted) begin
                    $error("muted: expected %0d, got %0d", want.muted, muted);
                    failed = 1'b1;
                end
                if (centered_units !== want.units) begin
                    $error("centered_units: expected %0d, got %0d", want.units, centered_units);
                    failed = 1'b1;
                end
            end
        end
    end

    // result side: random stalls, plus a long hold-off on request
    initial begin : drive_out_ready
        int hold_len;
        out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                hold_len = hold_request;
                hold_request = 0;
                out_ready <= 1'b0;
                repeat (hold_len) @(posedge i_clk);
            end
            out_ready <= !(stalls_on && $urandom_range(99) < 8);
        end
    end

    task automatic send_item(t_mode m, logic [11:0] s);
        while (gaps_on && $urandom_range(99) < 8) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        sample   <= s;
        do @(posedge i_clk); while (!in_ready);
        apply_event(m, s);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_config(logic [17:0] gain, logic [15:0] offset, logic [9:0] lockout);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_GAIN;
        cfg_data  <= gain;
        @(posedge i_clk);
        cfg_index <= CFG_OFFSET;
        cfg_data  <= 18'(offset);
        @(posedge i_clk);
        cfg_index <= CFG_LOCKOUT;
        cfg_data  <= 18'(lockout);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        gain_q16      = gain;
        level_offset  = offset;
        lockout_ticks = lockout;
    endtask

    function automatic logic [11:0] pick_sample();
        case ($urandom_range(7))
            0:       return 12'd0;
            1:       return 12'hFFF;
            2:       return 12'($urandom_range(1900, 2250));
            default: return 12'($urandom);
        endcase
    endfunction

    function automatic t_mode pick_mode();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 50) return MODE_SAMPLE;
        if (r < 80) return MODE_TICK;
        if (r < 90) return MODE_UNIT;
        return MODE_MUTE;
    endfunction

    task automatic random_burst(int count);
        repeat (count) send_item(pick_mode(), pick_sample());
    endtask

    // presses are ignored after reset; sample field is ignored outside samples
    task automatic test_reset_state();
        send_item(MODE_UNIT, 12'hFFF);
        send_item(MODE_MUTE, 12'hAAA);
        send_item(MODE_TICK, 12'h555);
        send_item(MODE_SAMPLE, 12'd1000);
        send_item(MODE_SAMPLE, 12'd4095);
        send_item(MODE_SAMPLE, 12'd2048);  // dead zone keeps buzzer B on
        send_item(MODE_SAMPLE, 12'd0);
    endtask

    task automatic test_presses_and_mute();
        set_config(GAIN_RESET, OFFSET_RESET, 10'd0);
        send_item(MODE_TICK, 12'd0);
        send_item(MODE_MUTE, 12'd0);
        send_item(MODE_MUTE, 12'd0);       // locked out
        send_item(MODE_SAMPLE, 12'd4095);  // muted: buzzers hold
        send_item(MODE_SAMPLE, 12'd1000);
        send_item(MODE_SAMPLE, 12'd0);
        send_item(MODE_TICK, 12'd0);
        send_item(MODE_MUTE, 12'd0);
        send_item(MODE_TICK, 12'd0);
        send_item(MODE_UNIT, 12'd0);
        send_item(MODE_SAMPLE, 12'd0);
        send_item(MODE_SAMPLE, 12'd4095);
        send_item(MODE_SAMPLE, 12'd2048);
    endtask

    // exact threshold levels fall through to the truncating branch
    task automatic test_level_boundaries();
        set_config(18'd65536, 16'd2000, 10'd0);
        send_item(MODE_SAMPLE, 12'd2800);
        send_item(MODE_SAMPLE, 12'd2801);
        send_item(MODE_SAMPLE, 12'd3100);
        set_config(18'd65536, 16'd0, 10'd0);
        send_item(MODE_SAMPLE, 12'd1700);
        send_item(MODE_SAMPLE, 12'd1699);
        set_config(18'd65536, 16'd4100, 10'd0);
        send_item(MODE_SAMPLE, 12'd4000);
        send_item(MODE_SAMPLE, 12'd4001);
    endtask

    task automatic test_config_extremes();
        set_config(18'd0, 16'd0, 10'd0);
        random_burst(20);
        set_config(18'h3FFFF, 16'hFFFF, 10'd1023);
        random_burst(20);
        set_config(18'h3FFFF, 16'd0, 10'd1);
        random_burst(20);
        set_config(18'd0, 16'hFFFF, 10'd512);
        random_burst(20);
        set_config(18'($urandom), 16'($urandom), 10'($urandom));
        random_burst(20);
    endtask

    // lockout compares strictly: a press needs more ticks than the limit
    task automatic test_lockout_strict();
        set_config(GAIN_RESET, OFFSET_RESET, 10'd0);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        send_item(MODE_TICK, 12'd0);
        send_item(MODE_UNIT, 12'd0);
        set_config(GAIN_RESET, OFFSET_RESET, 10'd20);
        repeat (20) send_item(MODE_TICK, 12'($urandom));
        send_item(MODE_UNIT, 12'd0);
        send_item(MODE_TICK, 12'd0);
        send_item(MODE_UNIT, 12'd0);
        set_config(GAIN_RESET, OFFSET_RESET, 10'd3);
        repeat (3) send_item(MODE_TICK, 12'd0);
        send_item(MODE_MUTE, 12'd0);
        send_item(MODE_TICK, 12'd0);
        send_item(MODE_MUTE, 12'd0);
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    task automatic test_backpressure();
        set_config(GAIN_RESET, OFFSET_RESET, 10'd2);
        gaps_on = 1'b0;
        hold_request = 60;
        random_burst(30);
        gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        set_config(GAIN_RESET, OFFSET_RESET, 10'($urandom_range(8)));
        random_burst(80);
        repeat (4) begin
            set_config(18'($urandom_range(40000, 140000)), 16'($urandom_range(3000)),
                       10'($urandom_range(20)));
            random_burst(60);
        end
        // long stretch without idling on either side
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        random_burst(120);
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    initial begin
        i_rst_n   <= 1'b0;
        in_valid  <= 1'b0;
        mode      <= MODE_SAMPLE;
        sample    <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_GAIN;
        cfg_data  <= '0;
        gain_q16      = GAIN_RESET;
        level_offset  = OFFSET_RESET;
        lockout_ticks = LOCKOUT_RESET;
        mapper_state  = '0;
        press_age     = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_presses_and_mute();
        test_level_boundaries();
        test_config_extremes();
        test_lockout_strict();
        test_backpressure();
        test_random_traffic();

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (!failed && pending_results.size() == 0) begin
            $display("joystick_servo_mapper: match");
        end else begin
            $display("joystick_servo_mapper: mismatch");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("joystick_servo_mapper: mismatch");
        $finish;
    end

endmodule
